FILE: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Cell layout, request and register codes, sequencer states and the
// result record passed from the sequencer to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	// default screen geometry
	localparam int SCREEN_ROWS_DEF = 25;
	localparam int SCREEN_COLS_DEF = 80;

	// fixed field widths
	localparam int IDX_W = 11;
	localparam int CFG_W = 5;

	// register reset values
	localparam logic [CFG_W-1:0] SCROLL_TOP_RST    = 5'd0;
	localparam logic [CFG_W-1:0] SCROLL_BOTTOM_RST = 5'd24;

	// character and attribute constants
	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] BLANK_ATTR = 8'h07;
	localparam logic [7:0] BOLD_ATTR  = 8'h09;

	// control codes and the printable window
	localparam logic [7:0] CODE_BS    = 8'h08;
	localparam logic [7:0] CODE_LF    = 8'h0A;
	localparam logic [7:0] CODE_CR    = 8'h0D;
	localparam logic [7:0] CODE_FIRST = 8'h08;
	localparam logic [7:0] CODE_LIMIT = 8'h80;

	typedef enum logic [1:0] {
		REQ_PUT   = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef enum logic {
		REG_SCROLL_TOP    = 1'b0,
		REG_SCROLL_BOTTOM = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] attr;
		logic [7:0] chr;
	} cell_t;

	localparam cell_t BLANK_CELL = '{attr: BLANK_ATTR, chr: BLANK_CHAR};

	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
		logic       scrolled;
	} res_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_SCR_A,
		ST_SCR_B,
		ST_SHIFT,
		ST_SHIFT_END,
		ST_BLANK,
		ST_CLEAR
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tcw_cell_mem.sv
// ----------------------------------------------------------------------------
// tcw_cell_mem: screen cell store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cell_mem #(
	parameter int DEPTH = tcw_pkg::SCREEN_ROWS_DEF * tcw_pkg::SCREEN_COLS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire tcw_pkg::cell_t wdata,
	input  wire logic [AW-1:0] raddr,
	output tcw_pkg::cell_t     rdata
);

	tcw_pkg::cell_t mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/tcw_seq.sv
// ----------------------------------------------------------------------------
// tcw_seq: request sequencer of the text console writer
// Holds the cursor, executes requests against the cell store and walks the
// store for the power-up clear, clear requests and region scrolls.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_seq #(
	parameter int ROWS = tcw_pkg::SCREEN_ROWS_DEF,
	parameter int COLS = tcw_pkg::SCREEN_COLS_DEF,
	parameter int RW   = $clog2(ROWS + 1),
	parameter int AW   = $clog2(ROWS * COLS)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// request
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [1:0]                req_type,
	input  wire logic [7:0]                char_code,
	input  wire logic [7:0]                attribute,
	input  wire logic                      bold,
	input  wire logic [tcw_pkg::IDX_W-1:0] cell_index,
	// clamped scrolling region
	input  wire logic [RW-1:0]             top_row,
	input  wire logic [RW-1:0]             bottom_row,
	// result
	output logic                           done,
	output tcw_pkg::res_t                  res,
	// cell store
	output logic                           mem_we,
	output logic [AW-1:0]                  mem_waddr,
	output tcw_pkg::cell_t                 mem_wdata,
	output logic [AW-1:0]                  mem_raddr,
	input  wire tcw_pkg::cell_t            mem_rdata
);

	localparam int NCELLS = ROWS * COLS;
	localparam int PW     = $clog2(NCELLS + 1);
	localparam int CW     = $clog2(COLS + 1);
	localparam int IW     = (PW > tcw_pkg::IDX_W) ? PW : tcw_pkg::IDX_W;

	localparam logic [PW-1:0] COLS_P = PW'(COLS);
	localparam logic [PW-1:0] LAST_P = PW'(NCELLS - 1);
	localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
	localparam logic [IW-1:0] NCELLS_I = IW'(NCELLS);

	tcw_pkg::state_t state_q, state_d;

	logic [RW-1:0] cur_row_q, row_d;
	logic [CW-1:0] cur_col_q, col_d;
	logic [PW-1:0] p_q, p_d;
	logic [PW-1:0] src_q, src_d;
	logic [PW-1:0] lim_q, lim_d;
	logic [PW-1:0] bend_q, bend_d;
	logic [PW-1:0] p_s1;
	logic          vld_s1, vld_d;

	// latched request
	tcw_pkg::req_t req_q;
	logic [7:0]    code_q;
	logic [7:0]    attr_q;
	logic          bold_q;
	logic          idx_ok_q;

	logic [IW-1:0] idx_ext;
	logic          idx_ok;
	logic          latch;

	logic          fin;
	logic          scr;
	tcw_pkg::res_t res_d;
	tcw_pkg::res_t res_q;
	logic          done_q;

	// put decode
	logic          put_ign;
	logic [RW-1:0] put_row;
	logic [CW-1:0] put_col;
	logic          put_wr;
	logic          put_chk;
	logic [PW-1:0] cur_addr;

	assign idx_ext = IW'(cell_index);
	assign idx_ok  = idx_ext < NCELLS_I;
	assign busy    = state_q != tcw_pkg::ST_IDLE;
	assign done    = done_q;
	assign res     = res_q;

	assign cur_addr = PW'(cur_row_q) * COLS_P + PW'(cur_col_q);

	// decode the character against the cursor
	always_comb begin
		put_ign = (code_q < tcw_pkg::CODE_FIRST) || (code_q >= tcw_pkg::CODE_LIMIT);
		put_row = cur_row_q;
		put_col = cur_col_q;
		put_wr  = 1'b0;
		put_chk = 1'b0;
		if (!put_ign) begin
			case (code_q)
				tcw_pkg::CODE_BS: begin
					if (cur_col_q != '0) begin
						put_col = cur_col_q - 1'b1;
					end
				end
				tcw_pkg::CODE_LF: begin
					put_col = '0;
					put_row = cur_row_q + 1'b1;
					put_chk = 1'b1;
				end
				tcw_pkg::CODE_CR: begin
					put_col = '0;
					put_chk = 1'b1;
				end
				default: begin
					put_wr  = 1'b1;
					put_chk = 1'b1;
					if (cur_col_q == COL_LAST) begin
						put_col = '0;
						put_row = cur_row_q + 1'b1;
					end else begin
						put_col = cur_col_q + 1'b1;
					end
				end
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, store access and result
	always_comb begin
		state_d   = state_q;
		row_d     = cur_row_q;
		col_d     = cur_col_q;
		p_d       = p_q;
		src_d     = src_q;
		lim_d     = lim_q;
		bend_d    = bend_q;
		vld_d     = 1'b0;
		latch     = 1'b0;
		fin       = 1'b0;
		scr       = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = p_q[AW-1:0];
		mem_wdata = tcw_pkg::BLANK_CELL;
		mem_raddr = src_q[AW-1:0];
		res_d     = '0;

		case (state_q)
			tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR: begin
				// sweep every cell to blank
				mem_we = 1'b1;
				p_d    = p_q + 1'b1;
				if (p_q == LAST_P) begin
					p_d     = '0;
					state_d = tcw_pkg::ST_IDLE;
					fin     = state_q == tcw_pkg::ST_CLEAR;
				end
			end
			tcw_pkg::ST_IDLE: begin
				// read the requested cell while the request is latched
				mem_raddr = idx_ext[AW-1:0];
				if (start) begin
					latch   = 1'b1;
					state_d = tcw_pkg::ST_EXEC;
				end
			end
			tcw_pkg::ST_EXEC: begin
				case (req_q)
					tcw_pkg::REQ_PUT: begin
						if (put_wr) begin
							mem_we         = 1'b1;
							mem_waddr      = cur_addr[AW-1:0];
							mem_wdata.chr  = code_q;
							mem_wdata.attr = bold_q ? tcw_pkg::BOLD_ATTR : attr_q;
						end
						row_d = put_row;
						col_d = put_col;
						if (put_chk && (put_row > bottom_row)) begin
							row_d   = bottom_row;
							state_d = tcw_pkg::ST_SCR_A;
						end else begin
							fin     = 1'b1;
							state_d = tcw_pkg::ST_IDLE;
						end
					end
					tcw_pkg::REQ_READ: begin
						if (idx_ok_q) begin
							res_d.cell_char = mem_rdata.chr;
							res_d.cell_attr = mem_rdata.attr;
						end
						fin     = 1'b1;
						state_d = tcw_pkg::ST_IDLE;
					end
					tcw_pkg::REQ_CLEAR: begin
						row_d   = '0;
						col_d   = '0;
						p_d     = '0;
						state_d = tcw_pkg::ST_CLEAR;
					end
					default: begin
						fin     = 1'b1;
						state_d = tcw_pkg::ST_IDLE;
					end
				endcase
			end
			tcw_pkg::ST_SCR_A: begin
				// destination starts at the top row
				p_d     = PW'(top_row) * COLS_P;
				state_d = tcw_pkg::ST_SCR_B;
			end
			tcw_pkg::ST_SCR_B: begin
				src_d   = p_q + COLS_P;
				lim_d   = PW'(bottom_row) * COLS_P;
				state_d = tcw_pkg::ST_SHIFT;
			end
			tcw_pkg::ST_SHIFT: begin
				// write back the cell read in the previous cycle
				if (vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = p_s1[AW-1:0];
					mem_wdata = mem_rdata;
				end
				if (p_q >= lim_q) begin
					state_d = tcw_pkg::ST_SHIFT_END;
				end else begin
					vld_d = 1'b1;
					p_d   = p_q + 1'b1;
					src_d = src_q + 1'b1;
				end
			end
			tcw_pkg::ST_SHIFT_END: begin
				// drain the last copy, then aim at the blank span
				if (vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = p_s1[AW-1:0];
					mem_wdata = mem_rdata;
				end
				p_d     = lim_q + PW'(cur_col_q);
				bend_d  = lim_q + COLS_P - 1'b1;
				state_d = tcw_pkg::ST_BLANK;
			end
			tcw_pkg::ST_BLANK: begin
				mem_we = 1'b1;
				p_d    = p_q + 1'b1;
				if (p_q == bend_q) begin
					fin     = 1'b1;
					scr     = 1'b1;
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcw_pkg::ST_IDLE;
			end
		endcase

		res_d.cursor_row = 5'(row_d);
		res_d.cursor_col = 7'(col_d);
		res_d.scrolled   = scr;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			p_q       <= '0;
			vld_s1    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			cur_row_q <= row_d;
			cur_col_q <= col_d;
			p_q       <= p_d;
			vld_s1    <= vld_d;
			done_q    <= fin;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		src_q  <= src_d;
		lim_q  <= lim_d;
		bend_q <= bend_d;
		p_s1   <= p_q;
		if (latch) begin
			req_q    <= tcw_pkg::req_t'(req_type);
			code_q   <= char_code;
			attr_q   <= attribute;
			bold_q   <= bold;
			idx_ok_q <= idx_ok;
		end
		if (fin) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console over a cell store with a cursor
// Top level: scrolling-region registers, cell store and request sequencer.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole store to blank cells (space, 0x07),
// one cell a cycle, with busy high; configuration writes are taken meanwhile.
// A request is taken when start is high and busy low. Put requests that do
// not scroll, read and ignored requests pass through one execution state, in
// which the registered read data of the cell store arrives, and then show
// their result. A clear walks every cell to blank. A put that scrolls copies
// the region one cell a cycle through the store's read and write ports, then
// blanks the bottom row from the cursor. Each result is shown for exactly one
// cycle with done high and the receiver cannot stall it; the next request may
// be taken at the edge that ends that cycle. cfg_ready is always high.
`default_nettype none

module text_console_writer #(
	parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF,
	parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic                      cfg_index,
	input  wire logic [tcw_pkg::CFG_W-1:0] cfg_data,
	// request
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [1:0]                req_type,
	input  wire logic [7:0]                char_code,
	input  wire logic [7:0]                attribute,
	input  wire logic                      bold,
	input  wire logic [tcw_pkg::IDX_W-1:0] cell_index,
	// result
	output logic                           done,
	output logic [7:0]                     cell_char,
	output logic [7:0]                     cell_attr,
	output logic [4:0]                     cursor_row,
	output logic [6:0]                     cursor_col,
	output logic                           scrolled
);

	localparam int NCELLS  = SCREEN_ROWS * SCREEN_COLS;
	localparam int AW      = $clog2(NCELLS);
	localparam int RW      = $clog2(SCREEN_ROWS + 1);
	localparam int ROW_MAX = SCREEN_ROWS - 1;

	logic [tcw_pkg::CFG_W-1:0] scroll_top_q;
	logic [tcw_pkg::CFG_W-1:0] scroll_bottom_q;
	logic [RW-1:0]             top_row;
	logic [RW-1:0]             bottom_row;

	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	tcw_pkg::cell_t mem_wdata;
	logic [AW-1:0]  mem_raddr;
	tcw_pkg::cell_t mem_rdata;
	tcw_pkg::res_t  res;

	assign cfg_ready = 1'b1;

	// region registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_top_q    <= tcw_pkg::SCROLL_TOP_RST;
			scroll_bottom_q <= tcw_pkg::SCROLL_BOTTOM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (tcw_pkg::reg_idx_t'(cfg_index))
				tcw_pkg::REG_SCROLL_TOP:    scroll_top_q    <= cfg_data;
				tcw_pkg::REG_SCROLL_BOTTOM: scroll_bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp the region to the last row
	always_comb begin
		top_row    = (int'(scroll_top_q) > ROW_MAX) ? RW'(ROW_MAX) : RW'(scroll_top_q);
		bottom_row = (int'(scroll_bottom_q) > ROW_MAX) ? RW'(ROW_MAX) : RW'(scroll_bottom_q);
	end

	tcw_cell_mem #(
		.DEPTH (NCELLS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tcw_seq #(
		.ROWS (SCREEN_ROWS),
		.COLS (SCREEN_COLS),
		.RW   (RW),
		.AW   (AW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.char_code  (char_code),
		.attribute  (attribute),
		.bold       (bold),
		.cell_index (cell_index),
		.top_row    (top_row),
		.bottom_row (bottom_row),
		.done       (done),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	assign cell_char  = res.cell_char;
	assign cell_attr  = res.cell_attr;
	assign cursor_row = res.cursor_row;
	assign cursor_col = res.cursor_col;
	assign scrolled   = res.scrolled;

	// a result strobe frees the request port in the same cycle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an accepted transaction always occupies the sequencer
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transaction accepted without going busy");

	// every result follows a cycle of work
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

endmodule

`default_nettype wire

FILE: tb/sv/tcw_console_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_console_checker: result checker for the text console writer
// Watches the register, request and result channels, keeps its own copy of
// the cell store, cursor and scrolling region, predicts one result per
// accepted request and compares each strobed result with the oldest one.
// ----------------------------------------------------------------------------

module tcw_console_checker #(
	parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF,
	parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [tcw_pkg::CFG_W-1:0] cfg_data,
	input  logic                      start,
	input  logic                      busy,
	input  logic [1:0]                req_type,
	input  logic [7:0]                char_code,
	input  logic [7:0]                attribute,
	input  logic                      bold,
	input  logic [tcw_pkg::IDX_W-1:0] cell_index,
	input  logic                      done,
	input  logic [7:0]                cell_char,
	input  logic [7:0]                cell_attr,
	input  logic [4:0]                cursor_row,
	input  logic [6:0]                cursor_col,
	input  logic                      scrolled,
	output int                        mismatch_count,
	output int                        awaited_count
);

	import tcw_pkg::*;

	localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;

	// predicted console state
	cell_t            screen [CELL_COUNT];
	int unsigned      crow;
	int unsigned      ccol;
	logic [CFG_W-1:0] top_reg;
	logic [CFG_W-1:0] bottom_reg;

	// results still to come, oldest first
	res_t awaited_results [$];
	res_t oldest;

	function automatic int unsigned clamp_row(logic [CFG_W-1:0] r);
		return (r > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : r;
	endfunction

	function automatic void blank_screen();
		foreach (screen[i])
			screen[i] = BLANK_CELL;
	endfunction

	// apply one put request; returns 1 when the region scrolled
	function automatic logic put_char(logic [7:0] code, logic [7:0] attr, logic bold_in);
		int unsigned top;
		int unsigned bot;
		cell_t       entry;
		top = clamp_row(top_reg);
		bot = clamp_row(bottom_reg);
		if (code < CODE_FIRST || code >= CODE_LIMIT)
			return 1'b0;
		if (code == CODE_BS) begin
			if (ccol > 0)
				ccol--;
			return 1'b0;
		end
		if (code == CODE_LF) begin
			ccol = 0;
			crow++;
		end else if (code == CODE_CR) begin
			ccol = 0;
		end else begin
			entry.chr  = code;
			entry.attr = bold_in ? BOLD_ATTR : attr;
			if (crow < SCREEN_ROWS && ccol < SCREEN_COLS)
				screen[crow * SCREEN_COLS + ccol] = entry;
			ccol++;
			if (ccol >= SCREEN_COLS) begin
				ccol = 0;
				crow++;
			end
		end
		if (crow <= bot)
			return 1'b0;
		// pin the cursor to the bottom row, move the region up, blank the tail
		crow = bot;
		for (int unsigned r = top; r < bot; r++)
			for (int unsigned c = 0; c < SCREEN_COLS; c++)
				screen[r * SCREEN_COLS + c] = screen[(r + 1) * SCREEN_COLS + c];
		for (int unsigned c = ccol; c < SCREEN_COLS; c++)
			screen[bot * SCREEN_COLS + c] = BLANK_CELL;
		return 1'b1;
	endfunction

	// predict the result of one request and update the console state
	function automatic res_t console_update(logic [1:0] rt, logic [7:0] code,
			logic [7:0] attr, logic bold_in, logic [IDX_W-1:0] idx);
		res_t r;
		r = '0;
		case (rt)
			REQ_PUT: r.scrolled = put_char(code, attr, bold_in);
			REQ_READ: begin
				if (idx < CELL_COUNT) begin
					r.cell_char = screen[idx].chr;
					r.cell_attr = screen[idx].attr;
				end
			end
			REQ_CLEAR: begin
				blank_screen();
				crow = 0;
				ccol = 0;
			end
			default: ;
		endcase
		r.cursor_row = crow[4:0];
		r.cursor_col = ccol[6:0];
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// track register writes, check results, then queue the new prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_screen();
			crow       = 0;
			ccol       = 0;
			top_reg    = SCROLL_TOP_RST;
			bottom_reg = SCROLL_BOTTOM_RST;
			mismatch_count = 0;
			awaited_results.delete();
			awaited_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SCROLL_TOP)
					top_reg = cfg_data;
				else
					bottom_reg = cfg_data;
			end
			if (done) begin
				if (awaited_results.size() == 0) begin
					$error("result strobe with no request outstanding");
					mismatch_count++;
				end else begin
					oldest = awaited_results.pop_front();
					compare_field("cell_char", oldest.cell_char, cell_char);
					compare_field("cell_attr", oldest.cell_attr, cell_attr);
					compare_field("cursor_row", 8'(oldest.cursor_row), 8'(cursor_row));
					compare_field("cursor_col", 8'(oldest.cursor_col), 8'(cursor_col));
					compare_field("scrolled", 8'(oldest.scrolled), 8'(scrolled));
				end
			end
			if (start && !busy)
				awaited_results.push_back(console_update(req_type, char_code,
					attribute, bold, cell_index));
			awaited_count <= awaited_results.size();
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the text console writer
// Drives a directed opening and then random text streams with reads, clears,
// control codes and ignored bytes over several scrolling regions, sending in
// bursts with random gaps in most phases. The checker predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_top;

	import tcw_pkg::*;

	localparam int SCREEN_ROWS = SCREEN_ROWS_DEF;
	localparam int SCREEN_COLS = SCREEN_COLS_DEF;
	localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;
	localparam int N_ITEMS     = 1800;
	localparam int N_PHASES    = 10;
	localparam int MAX_GAP     = 12;
	// every request as slow as a full scroll, plus its gap, several times over
	localparam int unsigned LIMIT =
		(N_ITEMS + 200) * (CELL_COUNT + 2 * SCREEN_COLS + MAX_GAP + 16) * 3;

	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	reg_idx_t             cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 start;
	logic                 busy;
	logic [1:0]           req_type;
	logic [7:0]           char_code;
	logic [7:0]           attribute;
	logic                 bold;
	logic [IDX_W-1:0]     cell_index;
	logic                 done;
	logic [7:0]           cell_char;
	logic [7:0]           cell_attr;
	logic [4:0]           cursor_row;
	logic [6:0]           cursor_col;
	logic                 scrolled;
	int                   mismatch_count;
	int                   awaited_count;

	int unsigned          cycle_count = 0;
	logic [4:0]           seen_row = '0;
	logic [6:0]           seen_col = '0;
	int                   line_left = 0;

	text_console_writer #(
		.SCREEN_ROWS(SCREEN_ROWS),
		.SCREEN_COLS(SCREEN_COLS)
	) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.req_type(req_type), .char_code(char_code), .attribute(attribute),
		.bold(bold), .cell_index(cell_index),
		.done(done), .cell_char(cell_char), .cell_attr(cell_attr),
		.cursor_row(cursor_row), .cursor_col(cursor_col), .scrolled(scrolled)
	);

	tcw_console_checker #(
		.SCREEN_ROWS(SCREEN_ROWS),
		.SCREEN_COLS(SCREEN_COLS)
	) checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.req_type(req_type), .char_code(char_code), .attribute(attribute),
		.bold(bold), .cell_index(cell_index),
		.done(done), .cell_char(cell_char), .cell_attr(cell_attr),
		.cursor_row(cursor_row), .cursor_col(cursor_col), .scrolled(scrolled),
		.mismatch_count(mismatch_count), .awaited_count(awaited_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// remember the last reported cursor to aim reads at fresh cells
	always @(posedge clk) begin
		if (done) begin
			seen_row <= cursor_row;
			seen_col <= cursor_col;
		end
	end

	// present one request and hold it until busy is seen low again
	task automatic issue(input logic [1:0] rt, input logic [7:0] code,
			input logic [7:0] attr, input logic b, input logic [IDX_W-1:0] idx);
		start      <= 1'b1;
		req_type   <= rt;
		char_code  <= code;
		attribute  <= attr;
		bold       <= b;
		cell_index <= idx;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// drop start and wait until every result is back
	task automatic settle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (awaited_count != 0);
		repeat (4) @(posedge clk);
	endtask

	// write both scrolling-region registers back to back
	task automatic set_region(input logic [CFG_W-1:0] t, input logic [CFG_W-1:0] b);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SCROLL_TOP;
		cfg_data  <= t;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_index <= REG_SCROLL_BOTTOM;
		cfg_data  <= b;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// draw one random request: mostly text lines, plus reads, clears and noise
	task automatic pick_request(output logic [1:0] rt, output logic [7:0] code,
			output logic [7:0] attr, output logic b, output logic [IDX_W-1:0] idx,
			output bit ignored);
		int roll;
		int last_cell;
		int pick;
		roll      = $urandom_range(0, 99);
		last_cell = seen_row * SCREEN_COLS + seen_col;
		rt        = REQ_PUT;
		code      = 8'($urandom_range(0, 255));
		attr      = 8'($urandom_range(0, 255));
		b         = ($urandom_range(0, 3) == 0);
		idx       = IDX_W'($urandom_range(0, 2 ** IDX_W - 1));
		ignored   = 1'b0;
		if (roll < 9) begin
			rt = REQ_READ;
			if (roll < 5 && last_cell > 0)
				idx = IDX_W'(last_cell - 1);
			else if (roll < 7)
				idx = IDX_W'($urandom_range(0, CELL_COUNT - 1));
		end else if (roll < 10) begin
			rt = REQ_CLEAR;
		end else if (roll < 12) begin
			ignored = 1'b1;
			if ($urandom_range(0, 1))
				rt = REQ_UNUSED;
			else if ($urandom_range(0, 1))
				code = 8'($urandom_range(0, CODE_FIRST - 1));
			else
				code = 8'($urandom_range(CODE_LIMIT, 255));
		end else if (roll < 15) begin
			code = CODE_BS;
		end else if (roll < 17) begin
			ignored = (code < CODE_FIRST || code >= CODE_LIMIT);
		end else if (line_left == 0) begin
			// end the line and choose the next length, some of them wrapping
			code = ($urandom_range(0, 4) == 0) ? CODE_CR : CODE_LF;
			pick = $urandom_range(0, 9);
			if (pick < 6)
				line_left = $urandom_range(0, 20);
			else if (pick < 9)
				line_left = $urandom_range(21, SCREEN_COLS - 1);
			else
				line_left = $urandom_range(SCREEN_COLS, 2 * SCREEN_COLS + 10);
		end else begin
			code = 8'($urandom_range(CODE_BS + 1, CODE_LIMIT - 1));
			if (code == CODE_LF || code == CODE_CR)
				code = BLANK_CHAR;
			line_left--;
		end
	endtask

	// region settings per phase, extremes and out-of-range values included
	logic [CFG_W-1:0] phase_top    [N_PHASES] = '{0, 20, 0, 24, 10, 31, 0, 22, 3, 0};
	logic [CFG_W-1:0] phase_bottom [N_PHASES] = '{24, 23, 1, 24, 3, 31, 0, 31, 5, 24};

	initial begin
		logic [1:0]       rt;
		logic [7:0]       code;
		logic [7:0]       attr;
		logic             b;
		logic [IDX_W-1:0] idx;
		bit               ignored;
		bit               gaps_on;
		int               counted;
		int               burst_left;

		arst_n     <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_index  <= REG_SCROLL_TOP;
		cfg_data   <= '0;
		start      <= 1'b0;
		req_type   <= REQ_PUT;
		char_code  <= '0;
		attribute  <= '0;
		bold       <= 1'b0;
		cell_index <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// registers may be written while the store is being cleared
		set_region(SCROLL_TOP_RST, SCROLL_BOTTOM_RST);

		// directed opening
		issue(REQ_READ, 8'h00, 8'h00, 1'b0, '0);
		issue(REQ_READ, 8'h00, 8'h00, 1'b0, IDX_W'(CELL_COUNT - 1));
		issue(REQ_READ, 8'h00, 8'h00, 1'b0, '1);
		issue(REQ_UNUSED, 8'hFF, 8'hFF, 1'b1, '1);
		issue(REQ_PUT, 8'h00, 8'hFF, 1'b1, '0);
		issue(REQ_PUT, CODE_FIRST - 8'd1, 8'h00, 1'b0, '0);
		issue(REQ_PUT, CODE_LIMIT, 8'h55, 1'b0, '0);
		issue(REQ_PUT, 8'hFF, 8'hAA, 1'b1, '0);
		issue(REQ_PUT, CODE_BS, 8'h00, 1'b0, '0);
		issue(REQ_PUT, 8'h41, 8'hFF, 1'b0, '0);
		issue(REQ_PUT, CODE_LIMIT - 8'd1, 8'h00, 1'b1, '0);
		issue(REQ_PUT, CODE_BS + 8'd1, 8'h5A, 1'b0, '0);
		issue(REQ_PUT, CODE_BS, 8'h00, 1'b0, '0);
		issue(REQ_READ, 8'h00, 8'h00, 1'b0, IDX_W'(0));
		issue(REQ_READ, 8'h00, 8'h00, 1'b0, IDX_W'(1));
		issue(REQ_PUT, CODE_CR, 8'h00, 1'b0, '0);
		issue(REQ_PUT, CODE_LF, 8'h00, 1'b0, '0);
		issue(REQ_PUT, BLANK_CHAR, 8'h80, 1'b0, '0);
		issue(REQ_READ, 8'h00, 8'h00, 1'b0, IDX_W'(SCREEN_COLS));
		// empty region with the cursor below it: a return scrolls
		settle();
		set_region(5'd0, 5'd0);
		issue(REQ_PUT, CODE_CR, 8'h00, 1'b0, '0);
		issue(REQ_READ, 8'h00, 8'h00, 1'b0, IDX_W'(SCREEN_COLS));
		issue(REQ_CLEAR, 8'h00, 8'h00, 1'b0, '0);
		issue(REQ_READ, 8'h00, 8'h00, 1'b0, IDX_W'(0));

		// random phases, one region setting each
		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			set_region(phase_top[p], phase_bottom[p]);
			gaps_on    = (p != 2 && p != 6);
			burst_left = $urandom_range(1, 40);
			counted    = 0;
			while (counted < N_ITEMS / N_PHASES) begin
				pick_request(rt, code, attr, b, idx, ignored);
				issue(rt, code, attr, b, idx);
				if (!ignored)
					counted++;
				// hold off once mid-run until every result is back
				if (p == 4 && counted == N_ITEMS / (2 * N_PHASES) && !ignored)
					settle();
				else if (gaps_on) begin
					if (burst_left == 0) begin
						start <= 1'b0;
						repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
						burst_left = $urandom_range(1, 40);
					end else begin
						burst_left--;
					end
				end
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_cell_mem.sv
hw/rtl/tcw_seq.sv
hw/rtl/text_console_writer.sv
tb/sv/tcw_console_checker.sv
tb/sv/tb_top.sv
